// ===== src/gmi_pkg.sv =====
// shared constants, types and codes of the group mean imputation block
package gmi_pkg;

	localparam int NUM_LOCATIONS = 64;
	localparam int NUM_APS = 16;
	localparam int MAX_SAMPLES = 1024;

	localparam int LOC_W = 6;
	localparam int AP_W = 4;
	localparam int SAMPLE_W = 8;
	localparam int APS_CFG_W = 5;
	localparam int SUM_W = 18;
	localparam int CNT_W = 11;

	localparam int TABLE_SIZE = NUM_LOCATIONS * NUM_APS;
	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int COUNT_CAP = (MAX_SAMPLES < 2047) ? MAX_SAMPLES : 2047;
	localparam int STEP_W = $clog2(SUM_W + 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [APS_CFG_W-1:0] ACTIVE_APS_RESET = APS_CFG_W'(16);

	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_FILL = 1'b1;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic is_fill;
		logic hit;
		logic [IDX_W-1:0] idx;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_LOOK  = 5'b00100,
		S_DIV   = 5'b01000,
		S_OUT   = 5'b10000
	} back_state_t;

endpackage

// ===== src/group_mean_imputation.sv =====
// top level of the group mean imputation block
// input channel: in_valid / in_stall with command, location, ap_index and
// sample_value; a word is taken when in_valid is high and in_stall low.
// output channel: out_valid / out_stall with filled_value and was_patched;
// only fill words give an output word, accumulate words give none.
// configuration: cfg_valid / cfg_ready writes active_aps; cfg_ready is always
// high and writes belong to idle periods.
// words pass through a two-word queue into a back end that handles one word
// at a time: an accumulate reads the table entry, then writes it back; a fill
// of a missing sample waits for the one-bit-a-cycle divider over the 18-bit
// sum; other fills go from the table read straight to the output register.
// after reset the table is cleared one entry a cycle, all 1024 entries, with
// in_stall high throughout; active_aps resets to 16.
// a stalled output word stays in the output register while the back end goes on
// with the next word; the queue then fills and in_stall rises.
module group_mean_imputation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [gmi_pkg::LOC_W-1:0]           location,
	input  logic [gmi_pkg::AP_W-1:0]            ap_index,
	input  logic signed [gmi_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gmi_pkg::SAMPLE_W-1:0] filled_value,
	output logic                                was_patched,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gmi_pkg::APS_CFG_W-1:0]       active_aps
);

	logic [gmi_pkg::APS_CFG_W-1:0] active_aps_q;
	gmi_pkg::queue_head_t head;
	gmi_pkg::back_status_t back_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_aps_q <= gmi_pkg::ACTIVE_APS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_aps_q <= active_aps;
		end
	end

	gmi_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.location(location),
		.ap_index(ap_index),
		.sample_value(sample_value),
		.active_aps_q(active_aps_q),
		.back_st(back_st),
		.head(head)
	);

	gmi_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.back_st(back_st),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filled_value(filled_value),
		.was_patched(was_patched)
	);

endmodule

// ===== src/gmi_ram.sv =====
// generic single write port, single read port ram with registered read
module gmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/gmi_front.sv =====
// input side: accepts words, classifies the group and queues them for the back end
module gmi_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  command,
	input  logic [gmi_pkg::LOC_W-1:0]             location,
	input  logic [gmi_pkg::AP_W-1:0]              ap_index,
	input  logic signed [gmi_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic [gmi_pkg::APS_CFG_W-1:0]         active_aps_q,
	input  gmi_pkg::back_status_t                 back_st,
	output gmi_pkg::queue_head_t                  head
);

	gmi_pkg::item_t fifo_q [gmi_pkg::QDEPTH];
	logic [gmi_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [gmi_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [gmi_pkg::QCNT_W-1:0] count_q;
	gmi_pkg::item_t new_item;
	logic hit;
	logic push;

	function automatic logic [gmi_pkg::APS_CFG_W-1:0] APS_CFG_W_ext(
		input logic [gmi_pkg::AP_W-1:0] ap);
		return gmi_pkg::APS_CFG_W'(ap);
	endfunction

	assign hit = (APS_CFG_W_ext(ap_index) < active_aps_q)
		&& (32'(ap_index) < gmi_pkg::NUM_APS)
		&& (32'(location) < gmi_pkg::NUM_LOCATIONS);

	always_comb begin
		new_item.is_fill = (command == gmi_pkg::CMD_FILL);
		new_item.hit = hit;
		new_item.idx = hit
			? gmi_pkg::IDX_W'(32'(location) * gmi_pkg::NUM_APS + 32'(ap_index))
			: '0;
		new_item.sample = sample_value;
	end

	assign in_stall = back_st.clearing || (count_q == gmi_pkg::QCNT_W'(gmi_pkg::QDEPTH));
	assign push = in_valid && !in_stall;

	assign head.valid = (count_q != '0);
	assign head.item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == gmi_pkg::QPTR_W'(gmi_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (back_st.pop) begin
				rd_ptr_q <= (rd_ptr_q == gmi_pkg::QPTR_W'(gmi_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, back_st.pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gmi_pkg::QCNT_W'(gmi_pkg::QDEPTH))
		else $error("queue fill beyond its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.pop |-> count_q != '0)
		else $error("pop from an empty queue");

endmodule

// ===== src/gmi_div.sv =====
// bit-serial divider of the sum magnitude by the count, clamped to a signed byte
module gmi_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [gmi_pkg::SUM_W-1:0]           dividend,
	input  logic                                neg,
	input  logic [gmi_pkg::CNT_W-1:0]           divisor,
	output logic                                done,
	output logic signed [gmi_pkg::SAMPLE_W-1:0] mean
);

	logic busy_q;
	logic done_q;
	logic [gmi_pkg::STEP_W-1:0] step_q;
	logic [gmi_pkg::SUM_W-1:0] quo_q;
	logic [gmi_pkg::CNT_W-1:0] rem_q;
	logic [gmi_pkg::CNT_W-1:0] div_q;
	logic neg_q;
	logic signed [gmi_pkg::SAMPLE_W-1:0] mean_q;
	logic [gmi_pkg::CNT_W:0] trial;
	logic take;
	logic [gmi_pkg::SUM_W-1:0] quo_next;
	logic [gmi_pkg::CNT_W-1:0] rem_next;
	logic big;
	logic signed [gmi_pkg::SAMPLE_W-1:0] mean_next;

	always_comb begin
		trial = {rem_q, quo_q[gmi_pkg::SUM_W-1]};
		take = (trial >= {1'b0, div_q});
		rem_next = take ? gmi_pkg::CNT_W'(trial - {1'b0, div_q})
			: trial[gmi_pkg::CNT_W-1:0];
		quo_next = {quo_q[gmi_pkg::SUM_W-2:0], take};
		big = |quo_next[gmi_pkg::SUM_W-1:gmi_pkg::SAMPLE_W-1];
		if (neg) begin
			mean_next = '0;
		end
		if (neg_q) begin
			mean_next = big ? {1'b1, {(gmi_pkg::SAMPLE_W-1){1'b0}}}
				: -$signed(quo_next[gmi_pkg::SAMPLE_W-1:0]);
		end else begin
			mean_next = big ? {1'b0, {(gmi_pkg::SAMPLE_W-1){1'b1}}}
				: $signed(quo_next[gmi_pkg::SAMPLE_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
		if (busy_q && step_q == gmi_pkg::STEP_W'(gmi_pkg::SUM_W - 1)) begin
			mean_q <= mean_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == gmi_pkg::STEP_W'(gmi_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign mean = mean_q;

endmodule

// ===== src/gmi_back.sv =====
// back end: clearing pass, table read-modify-write, mean division and output register
module gmi_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gmi_pkg::queue_head_t                head,
	output gmi_pkg::back_status_t               back_st,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gmi_pkg::SAMPLE_W-1:0] filled_value,
	output logic                                was_patched
);

	gmi_pkg::back_state_t state_q;
	gmi_pkg::back_state_t state_d;
	logic [gmi_pkg::IDX_W-1:0] clr_q;
	gmi_pkg::item_t item_q;
	logic signed [gmi_pkg::SAMPLE_W-1:0] res_val_q;
	logic res_patch_q;
	logic out_valid_q;
	logic signed [gmi_pkg::SAMPLE_W-1:0] out_val_q;
	logic out_patch_q;

	logic ram_we;
	logic [gmi_pkg::IDX_W-1:0] ram_waddr;
	logic [gmi_pkg::ENTRY_W-1:0] ram_wdata;
	logic [gmi_pkg::ENTRY_W-1:0] ram_rdata;
	gmi_pkg::entry_t rd;
	gmi_pkg::entry_t wr;

	logic signed [gmi_pkg::SUM_W:0] acc_sum;
	logic signed [gmi_pkg::SUM_W-1:0] sat_sum;
	logic can_acc;
	logic need_div;
	logic pop;
	logic load_out;
	logic div_start;
	logic div_done;
	logic [gmi_pkg::SUM_W-1:0] sum_mag;
	logic signed [gmi_pkg::SAMPLE_W-1:0] div_mean;

	gmi_ram #(
		.WIDTH(gmi_pkg::ENTRY_W),
		.DEPTH(gmi_pkg::TABLE_SIZE)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head.item.idx),
		.rdata(ram_rdata)
	);

	gmi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(sum_mag),
		.neg(rd.sum[gmi_pkg::SUM_W-1]),
		.divisor(rd.cnt),
		.done(div_done),
		.mean(div_mean)
	);

	assign rd = gmi_pkg::entry_t'(ram_rdata);
	assign sum_mag = rd.sum[gmi_pkg::SUM_W-1] ? gmi_pkg::SUM_W'(-rd.sum) : rd.sum;

	always_comb begin
		acc_sum = {rd.sum[gmi_pkg::SUM_W-1], rd.sum}
			+ {{(gmi_pkg::SUM_W + 1 - gmi_pkg::SAMPLE_W){item_q.sample[gmi_pkg::SAMPLE_W-1]}},
			   item_q.sample};
		if (acc_sum[gmi_pkg::SUM_W] != acc_sum[gmi_pkg::SUM_W-1]) begin
			sat_sum = acc_sum[gmi_pkg::SUM_W]
				? {1'b1, {(gmi_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(gmi_pkg::SUM_W-1){1'b1}}};
		end else begin
			sat_sum = acc_sum[gmi_pkg::SUM_W-1:0];
		end
		wr.sum = sat_sum;
		wr.cnt = rd.cnt + 1'b1;
	end

	assign can_acc = item_q.hit && (item_q.sample != '0)
		&& (rd.cnt < gmi_pkg::CNT_W'(gmi_pkg::COUNT_CAP));
	assign need_div = item_q.hit && (item_q.sample == '0) && (rd.cnt != '0);
	assign load_out = (state_q == gmi_pkg::S_OUT) && (!out_valid_q || !out_stall);
	assign pop = (state_q == gmi_pkg::S_IDLE) && head.valid;
	assign div_start = (state_q == gmi_pkg::S_LOOK) && item_q.is_fill && need_div;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = item_q.idx;
		ram_wdata = wr;
		state_d = state_q;
		unique case (state_q)
			gmi_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == gmi_pkg::IDX_W'(gmi_pkg::TABLE_SIZE - 1)) begin
					state_d = gmi_pkg::S_IDLE;
				end
			end
			gmi_pkg::S_IDLE: begin
				if (head.valid) begin
					state_d = gmi_pkg::S_LOOK;
				end
			end
			gmi_pkg::S_LOOK: begin
				if (!item_q.is_fill) begin
					ram_we = can_acc;
					state_d = gmi_pkg::S_IDLE;
				end else if (need_div) begin
					state_d = gmi_pkg::S_DIV;
				end else begin
					state_d = gmi_pkg::S_OUT;
				end
			end
			gmi_pkg::S_DIV: begin
				if (div_done) begin
					state_d = gmi_pkg::S_OUT;
				end
			end
			gmi_pkg::S_OUT: begin
				if (load_out) begin
					state_d = gmi_pkg::S_IDLE;
				end
			end
			default: state_d = gmi_pkg::S_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head.item;
		end
		if (state_q == gmi_pkg::S_LOOK) begin
			res_val_q <= item_q.sample;
			res_patch_q <= 1'b0;
		end else if (state_q == gmi_pkg::S_DIV && div_done) begin
			res_val_q <= div_mean;
			res_patch_q <= 1'b1;
		end
		if (load_out) begin
			out_val_q <= res_val_q;
			out_patch_q <= res_patch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmi_pkg::S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gmi_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign back_st.clearing = (state_q == gmi_pkg::S_CLEAR);
	assign back_st.pop = pop;
	assign out_valid = out_valid_q;
	assign filled_value = out_val_q;
	assign was_patched = out_patch_q;

	a_div_from_fill: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> item_q.is_fill && item_q.hit && item_q.sample == '0)
		else $error("division started for an item that needs none");

	a_write_only_accumulate: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != gmi_pkg::S_CLEAR |-> state_q == gmi_pkg::S_LOOK && !item_q.is_fill)
		else $error("table written outside an accumulate");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == gmi_pkg::S_DIV)
		else $error("divider finished with no division pending");

endmodule

// ===== dv/group_mean_imputation_test.sv =====
`timescale 1ns / 100ps
// testbench of the group mean imputation block: directed and random words checked against a group table model
module group_mean_imputation_test;
	import gmi_pkg::*;

	localparam int SETTLE_CYCLES = 60;
	localparam int SUM_HI = 131071;
	localparam int SUM_LO = -131072;
	localparam int RANDOM_WORDS = 780;
	localparam int PHASES = 6;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic patched;
	} fill_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_ACCUMULATE;
	logic [LOC_W-1:0] location = '0;
	logic [AP_W-1:0] ap_index = '0;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] filled_value;
	logic was_patched;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [APS_CFG_W-1:0] active_aps = ACTIVE_APS_RESET;

	int grp_sum [TABLE_SIZE];
	int grp_cnt [TABLE_SIZE];
	logic [APS_CFG_W-1:0] aps_in_use = ACTIVE_APS_RESET;
	fill_word_t fills_due [$];
	int fail_count = 0;
	bit calm = 1'b0;

	group_mean_imputation i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.location     (location),
		.ap_index     (ap_index),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filled_value (filled_value),
		.was_patched  (was_patched),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.active_aps   (active_aps)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// group table update, and the output word a fill gives
	function automatic void apply_word(logic cmd, logic [LOC_W-1:0] loc, logic [AP_W-1:0] ap,
			logic signed [SAMPLE_W-1:0] smp);
		int idx;
		bit in_use;
		int mean;
		fill_word_t res;
		in_use = (ap < aps_in_use) && (ap < NUM_APS) && (loc < NUM_LOCATIONS);
		idx = loc * NUM_APS + ap;
		if (cmd == CMD_ACCUMULATE) begin
			if (in_use && smp != 0 && grp_cnt[idx] < COUNT_CAP) begin
				grp_sum[idx] = grp_sum[idx] + int'(smp);
				if (grp_sum[idx] > SUM_HI) grp_sum[idx] = SUM_HI;
				if (grp_sum[idx] < SUM_LO) grp_sum[idx] = SUM_LO;
				grp_cnt[idx]++;
			end
		end else begin
			res.value = smp;
			res.patched = 1'b0;
			if (in_use && smp == 0 && grp_cnt[idx] > 0) begin
				mean = grp_sum[idx] / grp_cnt[idx];
				if (mean > 127) mean = 127;
				if (mean < -128) mean = -128;
				res.value = SAMPLE_W'(mean);
				res.patched = 1'b1;
			end
			fills_due.push_back(res);
		end
	endfunction

	task automatic send_word(input logic cmd, input logic [LOC_W-1:0] loc,
			input logic [AP_W-1:0] ap, input logic signed [SAMPLE_W-1:0] smp);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		location <= loc;
		ap_index <= ap;
		sample_value <= smp;
		do @(posedge clk); while (in_stall !== 1'b0);
		apply_word(cmd, loc, ap, smp);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (fills_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_aps(input logic [APS_CFG_W-1:0] aps);
		drain_results();
		cfg_valid <= 1'b1;
		active_aps <= aps;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		aps_in_use = aps;
	endtask

	task automatic send_random_word();
		logic cmd;
		logic [LOC_W-1:0] loc;
		logic [AP_W-1:0] ap;
		logic signed [SAMPLE_W-1:0] smp;
		cmd = ($urandom_range(0, 99) < 55) ? CMD_ACCUMULATE : CMD_FILL;
		loc = ($urandom_range(0, 4) == 0) ? LOC_W'($urandom_range(0, NUM_LOCATIONS - 1)) :
			LOC_W'($urandom_range(0, 7));
		ap = AP_W'($urandom_range(0, NUM_APS - 1));
		if ($urandom_range(0, 99) < ((cmd == CMD_FILL) ? 50 : 15)) begin
			smp = '0;
		end else begin
			smp = SAMPLE_W'($urandom);
		end
		send_word(cmd, loc, ap, smp);
	endtask

	task automatic test_empty_table();
		send_word(CMD_FILL, 0, 0, 0);
		send_word(CMD_FILL, 63, 15, 0);
		send_word(CMD_FILL, 5, 3, 127);
		send_word(CMD_FILL, 5, 3, -128);
	endtask

	task automatic test_group_means();
		send_word(CMD_ACCUMULATE, 0, 0, 5);
		send_word(CMD_ACCUMULATE, 0, 0, -2);
		send_word(CMD_ACCUMULATE, 0, 0, 0);
		send_word(CMD_FILL, 0, 0, 0);
		send_word(CMD_FILL, 0, 0, 9);
		// negative mean truncates toward zero
		send_word(CMD_ACCUMULATE, 1, 3, -7);
		send_word(CMD_ACCUMULATE, 1, 3, 2);
		send_word(CMD_FILL, 1, 3, 0);
		// zero mean still counts as patched
		send_word(CMD_ACCUMULATE, 2, 5, 3);
		send_word(CMD_ACCUMULATE, 2, 5, -3);
		send_word(CMD_FILL, 2, 5, 0);
		send_word(CMD_ACCUMULATE, 63, 15, 127);
		send_word(CMD_FILL, 63, 15, 0);
		send_word(CMD_ACCUMULATE, 62, 14, -128);
		send_word(CMD_FILL, 62, 14, 0);
	endtask

	task automatic test_ignored_aps();
		write_aps(4);
		send_word(CMD_ACCUMULATE, 0, 4, 50);
		send_word(CMD_FILL, 0, 4, 0);
		send_word(CMD_FILL, 0, 0, 0);
		write_aps(0);
		send_word(CMD_ACCUMULATE, 0, 0, 100);
		send_word(CMD_FILL, 0, 0, 0);
		write_aps(31);
		send_word(CMD_FILL, 63, 15, 0);
		write_aps(1);
		send_word(CMD_FILL, 0, 1, 0);
		send_word(CMD_FILL, 0, 0, 0);
	endtask

	// a group filled up to its count limit drops later samples
	task automatic test_full_count();
		write_aps(16);
		calm = 1'b1;
		for (int i = 0; i < COUNT_CAP + 4; i++) begin
			send_word(CMD_ACCUMULATE, 40, 9, -128);
		end
		send_word(CMD_FILL, 40, 9, 0);
		calm = 1'b0;
		repeat (3) send_word(CMD_ACCUMULATE, 40, 9, 127);
		send_word(CMD_FILL, 40, 9, 0);
	endtask

	task automatic test_random_mix();
		logic [APS_CFG_W-1:0] settings [PHASES];
		settings[0] = 16;
		settings[1] = 1;
		settings[2] = 0;
		settings[3] = 31;
		settings[4] = APS_CFG_W'($urandom_range(2, 15));
		settings[5] = APS_CFG_W'($urandom_range(0, 31));
		for (int p = 0; p < PHASES; p++) begin
			write_aps(settings[p]);
			calm = (p == 3);
			for (int i = 0; i < RANDOM_WORDS / PHASES; i++) begin
				if (p == 0 && i == RANDOM_WORDS / (2 * PHASES)) begin
					drain_results();
				end
				send_random_word();
			end
		end
		calm = 1'b0;
	endtask

	initial begin : result_checker
		int hold;
		fill_word_t want;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (fills_due.size() == 0) begin
				note_failure($sformatf("output word with none expected: filled_value %0d was_patched %b",
					filled_value, was_patched));
			end else begin
				want = fills_due.pop_front();
				if (filled_value !== want.value) begin
					note_failure($sformatf("filled_value mismatch: expected %0d got %0d",
						want.value, filled_value));
				end
				if (was_patched !== want.patched) begin
					note_failure($sformatf("was_patched mismatch: expected %b got %b",
						want.patched, was_patched));
				end
			end
		end
	end

	initial begin : test_sequence
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_group_means();
		test_ignored_aps();
		test_full_count();
		test_random_mix();
		drain_results();
		if (fail_count == 0 && fills_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
